@@ design/positional_list_engine_top_assert.svh @@
// Assertion macros used by the list engine control logic (plist_ctrl).
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is high.
`define PLIST_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
// Clocked check that also holds during reset.
`define PLIST_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define PLIST_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define PLIST_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)
`endif

`endif

@@ design/plist_pkg.sv @@
package plist_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  // fixed field widths of the stream words
  localparam int ACT_W    = 2;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 3;
  localparam int FOUND_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [ACT_W-1:0] ACT_INSERT    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEL_REAR  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SEARCH    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  // per-cell moves
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_LEFT  = 2'd1;  // take the entry in front (insert shift)
  localparam logic [1:0] OP_RIGHT = 2'd2;  // take the entry behind (delete front)
  localparam logic [1:0] OP_LOAD  = 2'd3;  // take the new value

  typedef struct packed {
    logic [1:0] op;
    logic       cmp;
  } cell_ctl_t;

endpackage

@@ design/plist_cell.sv @@
module plist_cell
  import plist_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [VAL_W-1:0] value,
  input  logic [VAL_W-1:0] left_entry,
  input  logic [VAL_W-1:0] right_entry,
  output logic [VAL_W-1:0] entry,
  output logic             match
);

  logic [VAL_W-1:0] entry_next;

  always_comb begin
    case (ctl.op)
      OP_HOLD:  entry_next = entry;
      OP_LEFT:  entry_next = left_entry;
      OP_RIGHT: entry_next = right_entry;
      OP_LOAD:  entry_next = value;
      default:  entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctl.cmp) begin
      match <= (entry == value);
    end
  end

endmodule

@@ design/plist_ctrl.sv @@
module plist_ctrl
  import plist_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ACT_W-1:0]    action,
  input  logic [POS_W-1:0]    position,
  output cell_ctl_t           cell_ctl [CAPACITY],
  input  logic [CAPACITY-1:0] match,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [STAT_W-1:0]   status,
  output logic [FOUND_W-1:0]  found_position,
  output logic [COUNT_W-1:0]  entry_count
);

  logic              accept;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [STAT_W-1:0] dec_status;
  logic              ins_ok;
  logic              front_ok;
  logic              rear_ok;
  logic              srch_ok;
  logic              busy;
  logic [STAT_W-1:0] pend_status;
  logic              pend_search;
  logic              out_load;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [CMP_W-1:0]  pos_ext;

  assign accept   = s_tvalid & s_tready;
  assign s_tready = ~busy;
  assign pos_ext  = CMP_W'(position);

  // request decode against the current count
  always_comb begin
    dec_status = ST_OK;
    ins_ok     = 1'b0;
    front_ok   = 1'b0;
    rear_ok    = 1'b0;
    srch_ok    = 1'b0;
    case (action)
      ACT_INSERT: begin
        if (pos_ext > CMP_W'(cnt)) begin
          dec_status = ST_BADPOS;
        end else if (cnt == CNT_W'(CAPACITY)) begin
          dec_status = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      ACT_DEL_FRONT: begin
        if (cnt == '0) dec_status = ST_EMPTY;
        else front_ok = 1'b1;
      end
      ACT_DEL_REAR: begin
        if (cnt == '0) dec_status = ST_EMPTY;
        else rear_ok = 1'b1;
      end
      ACT_SEARCH: begin
        if (cnt == '0) dec_status = ST_EMPTY;
        else srch_ok = 1'b1;
      end
      default: dec_status = ST_OK;
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    if (accept && ins_ok) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (accept && (front_ok || rear_ok)) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  // cell moves
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i].op  = OP_HOLD;
      cell_ctl[i].cmp = accept & srch_ok;
      if (accept && ins_ok) begin
        if (CMP_W'(i) == pos_ext) cell_ctl[i].op = OP_LOAD;
        else if (CMP_W'(i) > pos_ext) cell_ctl[i].op = OP_LEFT;
      end else if (accept && front_ok) begin
        cell_ctl[i].op = OP_RIGHT;
      end
    end
  end

  // first live match, lowest index wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i] && (CNT_W'(i) < cnt)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign out_load = busy & (~m_tvalid | m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        busy <= 1'b1;
      end else if (out_load) begin
        busy <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= dec_status;
      pend_search <= srch_ok;
    end
    if (out_load) begin
      entry_count    <= COUNT_W'(cnt);
      status         <= pend_status;
      found_position <= '0;
      if (pend_search) begin
        if (hit) begin
          found_position <= FOUND_W'(hit_idx);
        end else begin
          status <= ST_NOTFOUND;
        end
      end
    end
  end

`include "positional_list_engine_top_assert.svh"

  `PLIST_ASSERT(a_cnt_bound, clk, rst, cnt <= CNT_W'(CAPACITY), "count above capacity")
  `PLIST_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> (!m_tvalid && !busy), "not idle after reset")
  `PLIST_ASSERT(a_cnt_quiet, clk, rst, !accept |=> $stable(cnt), "count moved without a request")
  `PLIST_ASSERT(a_busy_after_acc, clk, rst, accept |=> busy, "accepted word not pending")
  `PLIST_ASSERT(a_found_ok, clk, rst, (m_tvalid && found_position != '0) |-> (status == ST_OK && COUNT_W'(found_position) < entry_count), "found position inconsistent")

endmodule

@@ design/positional_list_engine_top.sv @@
// Positional list engine: an ordered list of up to 64 signed 32-bit values.
// Input channel s_*: one word per request. s_tuser carries the action
// (insert at position, delete front, delete rear, search); s_tdata carries
// the value or search key and the insert position.
// Output channel m_*: exactly one word per request with the status, the
// position of the first match (searches only) and the count after the request.
// The list lives in a row of 64 cells; each cell holds one entry and passes
// it to both neighbours, so an insert shifts the tail back, a delete-front
// shifts everything forward and a search compares all cells at once, all in
// the accept cycle.
// The result word is registered: an accepted request is held pending, then
// loaded into the output register. The input is held off while a request is
// pending; its result (match priority encode for searches) is loaded into the
// output register as soon as that register is free.
// A result waiting on a stalled m_tready does not block the next request:
// it is accepted and its result holds until the output register frees up;
// further requests wait until then.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
module positional_list_engine_top
  import plist_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [38:32] position, [39] zero pad
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [2:0] status, [8:3] found_position, [15:9] entry_count
);

  logic [VAL_W-1:0]    value;
  logic [POS_W-1:0]    position;
  logic [VAL_W-1:0]    entry [CAPACITY];
  logic [CAPACITY-1:0] match;
  cell_ctl_t           cell_ctl [CAPACITY];
  logic [STAT_W-1:0]   status;
  logic [FOUND_W-1:0]  found_position;
  logic [COUNT_W-1:0]  entry_count;

  assign value    = s_tdata[31:0];
  assign position = s_tdata[38:32];

  plist_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .action         (s_tuser),
    .position       (position),
    .cell_ctl       (cell_ctl),
    .match          (match),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .status         (status),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

  // Cell chain, front at cell 0. The ends see zero beyond the row.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_entry;
    logic [VAL_W-1:0] right_entry;

    if (g == 0) begin : g_front
      assign left_entry = '0;
    end else begin : g_mid_l
      assign left_entry = entry[g-1];
    end

    if (g == CAPACITY - 1) begin : g_rear
      assign right_entry = '0;
    end else begin : g_mid_r
      assign right_entry = entry[g+1];
    end

    plist_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[g]),
      .value       (value),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry[g]),
      .match       (match[g])
    );
  end

  assign m_tdata = {entry_count, found_position, status};

endmodule

@@ dv/positional_list_engine_top_test.sv @@
`timescale 1ns / 100ps

module positional_list_engine_top_test;
  import plist_pkg::*;

  localparam int STALL_BURST_CYCLES = 300;
  localparam int WATCHDOG_CYCLES    = 2000;
  localparam int DRAIN_CYCLES       = 8;

  // one result word, unpacked
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FOUND_W-1:0] found;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;  // [31:0] value, [38:32] position, [39] zero pad
  logic [1:0]  s_tuser  = '0;  // [1:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [2:0] status, [8:3] found_position, [15:9] entry_count

  positional_list_engine_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow copy of the list, front at index 0, updated as each word is taken.
  logic [VAL_W-1:0] list_model [CAPACITY];
  int               model_len = 0;

  list_result_t predicted_results [$];
  int           mismatches    = 0;
  int           results_seen  = 0;
  int           src_idle_pct  = 36;
  int           sink_idle_pct = 36;
  logic         stall_burst   = 1'b0;
  int           quiet_cycles  = 0;
  event         stall_burst_start;

  // Applies one request to the shadow list and returns the result it should give.
  function automatic list_result_t apply_list_request(logic [ACT_W-1:0] act,
                                                      logic [VAL_W-1:0] val,
                                                      logic [POS_W-1:0] pos);
    list_result_t r;
    int           i;
    logic         hit;
    r.status = ST_OK;
    r.found  = '0;
    hit      = 1'b0;
    case (act)
      ACT_INSERT: begin
        // position is checked before capacity
        if (int'(pos) > model_len) begin
          r.status = ST_BADPOS;
        end else if (model_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = model_len; i > int'(pos); i--) list_model[i] = list_model[i-1];
          list_model[pos] = val;
          model_len++;
        end
      end
      ACT_DEL_FRONT: begin
        if (model_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 0; i < model_len - 1; i++) list_model[i] = list_model[i+1];
          model_len--;
        end
      end
      ACT_DEL_REAR: begin
        if (model_len == 0) r.status = ST_EMPTY;
        else model_len--;
      end
      default: begin
        if (model_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // first match wins
          for (i = 0; i < model_len; i++) begin
            if (!hit && list_model[i] == val) begin
              hit     = 1'b1;
              r.found = i[FOUND_W-1:0];
            end
          end
          if (!hit) r.status = ST_NOTFOUND;
        end
      end
    endcase
    r.count = model_len[COUNT_W-1:0];
    return r;
  endfunction

  // Offers one word, with random gaps in front of it, and predicts its result
  // at the edge where it is taken.
  task automatic issue_request(logic [ACT_W-1:0] act, logic [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, pos, val};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    predicted_results.push_back(apply_list_request(act, val, pos));
  endtask

  // Sender stops and waits until every outstanding result has come back.
  task automatic wait_all_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  // Extremes plus a small pool, so searches hit duplicates often.
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return VAL_W'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_request(int ins_pct, output logic [ACT_W-1:0] act,
                              output logic [VAL_W-1:0] val, output logic [POS_W-1:0] pos);
    int r;
    r   = $urandom_range(99);
    val = rand_value();
    pos = POS_W'($urandom_range(CAPACITY));
    if (r < ins_pct) begin
      act = ACT_INSERT;
      case ($urandom_range(9))
        7:       pos = POS_W'(model_len);
        8:       pos = '0;
        9:       pos = (model_len < CAPACITY) ?
                       POS_W'($urandom_range(CAPACITY, model_len + 1)) : POS_W'(CAPACITY);
        default: pos = POS_W'($urandom_range(model_len));
      endcase
    end else if (r < ins_pct + (100 - ins_pct) / 2) begin
      act = ACT_SEARCH;
      if (model_len > 0 && $urandom_range(1))
        val = list_model[$urandom_range(model_len - 1)];
    end else begin
      act = $urandom_range(1) ? ACT_DEL_FRONT : ACT_DEL_REAR;
    end
  endtask

  task automatic run_random(int n, int ins_pct);
    logic [ACT_W-1:0] act;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    repeat (n) begin
      pick_request(ins_pct, act, val, pos);
      issue_request(act, val, pos);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Every action on an empty list, and inserts beyond the end.
  task automatic test_empty_list();
    issue_request(ACT_DEL_FRONT, 32'h0, 7'd0);
    issue_request(ACT_DEL_REAR, 32'h0, 7'd0);
    issue_request(ACT_SEARCH, 32'h0, 7'd0);
    issue_request(ACT_INSERT, 32'h1234_5678, 7'd1);
    issue_request(ACT_INSERT, 32'hFFFF_FFFF, 7'd64);
  endtask

  // Value extremes, front/middle/rear inserts, duplicate keys, misses.
  task automatic test_directed_ops();
    issue_request(ACT_INSERT, 32'h7FFF_FFFF, 7'd0);
    issue_request(ACT_INSERT, 32'h8000_0000, 7'd0);
    issue_request(ACT_INSERT, 32'h0000_0000, 7'd2);   // append
    issue_request(ACT_INSERT, 32'hFFFF_FFFF, 7'd1);   // middle
    issue_request(ACT_INSERT, 32'h5555_5555, 7'd5);   // one past the end
    issue_request(ACT_INSERT, 32'h8000_0000, 7'd4);   // duplicate at rear
    issue_request(ACT_SEARCH, 32'h8000_0000, 7'd0);   // first of two copies
    issue_request(ACT_SEARCH, 32'h0000_0000, 7'd64);
    issue_request(ACT_SEARCH, 32'h7FFF_FFFF, 7'd0);
    issue_request(ACT_SEARCH, 32'h0000_0001, 7'd0);   // miss
    issue_request(ACT_DEL_FRONT, 32'hFFFF_FFFF, 7'd64);
    issue_request(ACT_SEARCH, 32'h8000_0000, 7'd0);   // now only the rear copy
    issue_request(ACT_DEL_REAR, 32'h0, 7'd63);
    issue_request(ACT_SEARCH, 32'h8000_0000, 7'd0);
    issue_request(ACT_DEL_REAR, 32'h0, 7'd127 & 7'd64);
    issue_request(ACT_DEL_REAR, 32'h0, 7'd0);
    issue_request(ACT_DEL_FRONT, 32'h0, 7'd1);
    issue_request(ACT_DEL_FRONT, 32'h0, 7'd0);        // empty again
  endtask

  // Fill the list to capacity, push on it while full, then drain past empty.
  task automatic test_fill_and_drain(int rounds);
    int n;
    repeat (rounds) begin
      n = 0;
      while (model_len < CAPACITY && n < 400) begin
        run_random(1, 85);
        n++;
      end
      run_random(12, 60);
      n = 0;
      while (model_len > 0 && n < 400) begin
        run_random(1, 10);
        n++;
      end
      run_random(4, 0);
    end
  endtask

  task automatic test_random_mix(int n);
    run_random(n, 40);
  endtask

  // Long receiver hold while the sender keeps offering, then a full drain.
  task automatic test_backpressure();
    int saved;
    saved        = src_idle_pct;
    src_idle_pct = 0;
    -> stall_burst_start;
    run_random(60, 50);
    src_idle_pct = saved;
    run_random(140, 45);
    wait_all_results();
  endtask

  // A stretch with neither side idling.
  task automatic test_no_idle(int n);
    int saved_src;
    int saved_sink;
    saved_src     = src_idle_pct;
    saved_sink    = sink_idle_pct;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(n, 45);
    src_idle_pct  = saved_src;
    sink_idle_pct = saved_sink;
  endtask

  // ---------------------------------------------------------------- receiver

  always begin
    @(stall_burst_start);
    stall_burst <= 1'b1;
    repeat (STALL_BURST_CYCLES) @(posedge clk);
    stall_burst <= 1'b0;
  end

  always @(negedge clk) begin
    if (stall_burst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Each taken result word against the oldest prediction.
  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[2:0];
      got.found  = m_tdata[8:3];
      got.count  = m_tdata[15:9];
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %h after %0d results", m_tdata, results_seen);
      end else begin
        want = predicted_results.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: status %0d/%0d found %0d/%0d count %0d/%0d (exp/got)",
                     results_seen, want.status, got.status, want.found, got.found,
                     want.count, got.count);
        end
      end
      results_seen++;
    end
  end

  // Watchdog: too long with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("positional_list_engine_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_directed_ops();
    test_fill_and_drain(4);
    test_random_mix(300);
    test_backpressure();
    test_no_idle(300);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("positional_list_engine_top test passed");
    else
      $display("positional_list_engine_top test failed");
    $finish;
  end

endmodule
